### hdl/tfddc_pkg.sv
// Package for the fan duty and display controller.
// Holds field widths, register defaults, duty values, a segment decode function and a step duty function.
// No dependencies.
package tfddc_pkg;

  localparam int SAMPLE_W = 10;
  localparam int TEMP_W   = 7;
  localparam int DUTY_W   = 10;
  localparam int SEG_W    = 7;
  localparam int STEP_W   = 2;
  localparam int DIGIT_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam int SCALE_MUL = 500;
  localparam int SCALE_DIV = 1023;
  localparam int TEMP_MAX  = 99;
  localparam int PROD_W    = 17;
  localparam int SHIFT_W   = 10;

  // Smallest sample whose scaled value exceeds the saturation point.
  localparam logic [SAMPLE_W-1:0] SAT_SAMPLE =
    SAMPLE_W'(((TEMP_MAX + 1) * SCALE_DIV + SCALE_MUL - 1) / SCALE_MUL);

  localparam logic [TEMP_W-1:0] COOL_LIMIT_RST = 7'd30;
  localparam logic [TEMP_W-1:0] WARM_LIMIT_RST = 7'd35;

  localparam logic [DUTY_W-1:0] DUTY_LOW  = 10'd100;
  localparam logic [DUTY_W-1:0] DUTY_MID  = 10'd500;
  localparam logic [DUTY_W-1:0] DUTY_HIGH = 10'd900;

  localparam logic [SEG_W-1:0] GLYPH_SPECIAL = 7'd62;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COOL_LIMIT = 1'b0,
    CFG_WARM_LIMIT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic [SEG_W-1:0]  tens_segments;
    logic [SEG_W-1:0]  ones_segments;
  } temp_disp_t;

  typedef struct packed {
    logic [DUTY_W-1:0] fan_duty;
    logic [TEMP_W-1:0] temperature;
    logic [SEG_W-1:0]  tens_segments;
    logic [SEG_W-1:0]  ones_segments;
    logic [SEG_W-1:0]  mode_segments;
    logic              manual_active;
  } result_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'd0: seg = 7'h3F;
      4'd1: seg = 7'h06;
      4'd2: seg = 7'h5B;
      4'd3: seg = 7'h4F;
      4'd4: seg = 7'h66;
      4'd5: seg = 7'h6D;
      4'd6: seg = 7'h7D;
      4'd7: seg = 7'h07;
      4'd8: seg = 7'h7F;
      4'd9: seg = 7'h6F;
      default: seg = '0;
    endcase
    return seg;
  endfunction

  function automatic logic [DUTY_W-1:0] step_duty(input logic [STEP_W-1:0] step);
    logic [DUTY_W-1:0] duty;
    case (step)
      2'd0: duty = 10'd100;
      2'd1: duty = 10'd300;
      2'd2: duty = 10'd600;
      2'd3: duty = 10'd900;
      default: duty = 10'd100;
    endcase
    return duty;
  endfunction

endpackage

### hdl/tfddc_if.sv
// Channel interfaces for the fan duty and display controller.
// Depends on tfddc_pkg for field widths.
interface tfddc_in_if;
  import tfddc_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sensor_sample;
  logic                button_a_down;
  logic                button_b_down;

  modport source (output valid, sensor_sample, button_a_down, button_b_down, input ready);
  modport sink   (input valid, sensor_sample, button_a_down, button_b_down, output ready);
endinterface

interface tfddc_out_if;
  import tfddc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] fan_duty;
  logic [TEMP_W-1:0] temperature;
  logic [SEG_W-1:0]  tens_segments;
  logic [SEG_W-1:0]  ones_segments;
  logic [SEG_W-1:0]  mode_segments;
  logic              manual_active;

  modport source (output valid, fan_duty, temperature, tens_segments, ones_segments,
                  mode_segments, manual_active, input ready);
  modport sink   (input valid, fan_duty, temperature, tens_segments, ones_segments,
                  mode_segments, manual_active, output ready);
endinterface

### hdl/tfddc_temp_decode.sv
// Sensor sample scaling to degrees and seven-segment decode of the two digits.
// Depends on tfddc_pkg.
module tfddc_temp_decode (
  input  logic [tfddc_pkg::SAMPLE_W-1:0] sample,
  output tfddc_pkg::temp_disp_t          disp
);
  import tfddc_pkg::*;

  logic [PROD_W-1:0]  prod;
  logic [TEMP_W-1:0]  q0;
  logic [PROD_W-1:0]  q0_times_div;
  logic [PROD_W-1:0]  rem;
  logic [TEMP_W-1:0]  temp;
  logic [14:0]        tens_prod;
  logic [DIGIT_W-1:0] tens;
  logic [TEMP_W-1:0]  ones_full;

  // Below saturation the product fits 17 bits; dividing by 1024 undershoots the
  // quotient by at most one, which a single remainder compare corrects.
  always_comb begin
    prod         = PROD_W'(sample) * PROD_W'(SCALE_MUL);
    q0           = prod[PROD_W-1:SHIFT_W];
    q0_times_div = {q0, {SHIFT_W{1'b0}}} - PROD_W'(q0);
    rem          = prod - q0_times_div;
    if (sample >= SAT_SAMPLE) begin
      temp = TEMP_W'(TEMP_MAX);
    end else if (rem >= PROD_W'(SCALE_DIV)) begin
      temp = q0 + 7'd1;
    end else begin
      temp = q0;
    end
    tens_prod = 15'(temp) * 15'd205;
    tens      = tens_prod[14:11];
    ones_full = temp - TEMP_W'(tens) * 7'd10;

    disp.temperature   = temp;
    disp.tens_segments = seg_of(tens);
    disp.ones_segments = seg_of(ones_full[DIGIT_W-1:0]);
  end

endmodule

### hdl/temp_fan_duty_display_ctrl_unit.sv
// Fan duty and display controller: one word per control tick in, one word out.
// Each word is registered at the input, decoded in one pass and registered at the
// output, so a new word is taken every cycle while the output is not stalled.
// A stalled output holds the output register, then the input register, and then the
// input. Depends on tfddc_pkg, tfddc_if and tfddc_temp_decode.
module temp_fan_duty_display_ctrl_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  tfddc_in_if.sink                          in_ch,
  tfddc_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [tfddc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tfddc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tfddc_pkg::*;

  logic [TEMP_W-1:0]   cool_limit_r;
  logic [TEMP_W-1:0]   warm_limit_r;
  logic                manual_mode_r, manual_mode_nxt;
  logic [STEP_W-1:0]   manual_step_r, manual_step_nxt;
  logic                blink_phase_r, blink_phase_nxt;

  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                s1_a_r;
  logic                s1_b_r;
  logic                s1_ready;
  logic                s1_fire;

  logic                out_valid_r;
  result_t             out_r, out_nxt;

  temp_disp_t          disp;
  logic                both;
  logic                hot;
  logic                blank;

  assign s1_ready    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && s1_ready;
  assign in_ch.ready = !s1_valid_r || s1_ready;

  tfddc_temp_decode u_decode (
    .sample (s1_sample_r),
    .disp   (disp)
  );

  always_comb begin
    both            = s1_a_r && s1_b_r;
    manual_mode_nxt = both ? manual_mode_r : (manual_mode_r ^ s1_a_r);
    manual_step_nxt = (!both && s1_b_r && manual_mode_nxt) ? manual_step_r + 2'd1
                                                           : manual_step_r;
    hot             = disp.temperature > warm_limit_r;
    blank           = !both && hot && blink_phase_r;
    blink_phase_nxt = (!both && hot) ? !blink_phase_r : blink_phase_r;

    if (both) begin
      out_nxt.fan_duty = DUTY_LOW;
    end else if (manual_mode_nxt) begin
      out_nxt.fan_duty = step_duty(manual_step_nxt);
    end else if (disp.temperature <= cool_limit_r) begin
      out_nxt.fan_duty = DUTY_HIGH;
    end else if (disp.temperature <= warm_limit_r) begin
      out_nxt.fan_duty = DUTY_MID;
    end else begin
      out_nxt.fan_duty = DUTY_LOW;
    end

    out_nxt.temperature   = disp.temperature;
    out_nxt.tens_segments = blank ? '0 : disp.tens_segments;
    out_nxt.ones_segments = blank ? '0 : disp.ones_segments;
    out_nxt.mode_segments = both ? GLYPH_SPECIAL : seg_of(DIGIT_W'(manual_mode_nxt));
    out_nxt.manual_active = manual_mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cool_limit_r  <= COOL_LIMIT_RST;
      warm_limit_r  <= WARM_LIMIT_RST;
      manual_mode_r <= 1'b0;
      manual_step_r <= '0;
      blink_phase_r <= 1'b0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_COOL_LIMIT: cool_limit_r <= TEMP_W'(cfg_data);
          CFG_WARM_LIMIT: warm_limit_r <= TEMP_W'(cfg_data);
          default: ;
        endcase
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        manual_mode_r <= manual_mode_nxt;
        manual_step_r <= manual_step_nxt;
        blink_phase_r <= blink_phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sample_r <= in_ch.sensor_sample;
      s1_a_r      <= in_ch.button_a_down;
      s1_b_r      <= in_ch.button_b_down;
    end
    if (s1_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fan_duty      = out_r.fan_duty;
  assign out_ch.temperature   = out_r.temperature;
  assign out_ch.tens_segments = out_r.tens_segments;
  assign out_ch.ones_segments = out_r.ones_segments;
  assign out_ch.mode_segments = out_r.mode_segments;
  assign out_ch.manual_active = out_r.manual_active;

endmodule
